@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers; they compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked only while out of reset
`define PSG_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("psg assertion failed");
// checked at every edge, reset included
`define PSG_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("psg assertion failed");
`else
`define PSG_ASSERT(label, clk, rst_n, prop)
`define PSG_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ src/psg_pkg.sv @@
// ----------------------------------------------------------------------------
// PSG package
// Commands, register write bundles and timing constants of the sound generator.
// ----------------------------------------------------------------------------
package psg_pkg;

  // chip ticks advanced per output sample (range 1..16)
  localparam int unsigned TICKS_PER_SAMPLE = 6;

  localparam logic [11:0] TONE_TICKS  = 12'(TICKS_PER_SAMPLE);
  localparam logic [4:0]  NOISE_TICKS = 5'(TICKS_PER_SAMPLE);

  localparam logic [10:0] PERIOD_ZERO = 11'h400;
  localparam logic [15:0] LFSR_SEED   = 16'h8000;
  localparam logic [1:0]  NOISE_SEL   = 2'd3;
  localparam logic [1:0]  NOISE_TONE2 = 2'd3;
  localparam logic [7:0]  READ_VALUE  = 8'h03;

  typedef enum logic [1:0] {
    CMD_LATCH  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_NOP    = 2'd3
  } psg_cmd_t;

  // register write to one tone channel
  typedef struct packed {
    logic       en;
    logic       amp;   // attenuation write
    logic       lo;    // period bits 3..0
    logic       hi;    // period bits 9..4
    logic [5:0] data;
  } psg_tone_wr_t;

  // register write to the noise channel
  typedef struct packed {
    logic       en;
    logic       amp;   // attenuation write, else control write
    logic [3:0] data;
  } psg_noise_wr_t;

endpackage

@@ src/psg_tone_noise_generator.sv @@
// ----------------------------------------------------------------------------
// PSG tone and noise generator
// Four-voice sound generator: three square tones, one LFSR noise, lowpass mix.
// ----------------------------------------------------------------------------
// Every item yields exactly one result, in order. An item goes into an input
// register; when the result register can take it, the channel logic and the
// mixer/filter work on it in one pass and load the result register, so a new
// item is taken in every cycle unless out_ready stalls the result register:
// throughput is one item per clock while the output is not stalled. in_ready
// drops only while both the input and result registers hold items and
// out_ready is low. cmd 0 latches data_byte, cmd 1 applies the latched byte
// to the voice registers and reads back 3, cmd 2 advances all voices by
// TICKS_PER_SAMPLE chip ticks and returns the filtered sample, cmd 3 does
// nothing. Unused result fields read as zero.
module psg_tone_noise_generator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_result_kind,
  output logic [7:0]         out_read_data,
  output logic signed [15:0] out_sample
);
  import psg_pkg::*;
  `include "assert_macros.svh"

  // input register
  logic       in_v_r, in_v_nxt;
  logic [1:0] in_cmd_r;
  logic [7:0] in_byte_r;

  // result register
  logic               out_v_r, out_v_nxt;
  logic [1:0]         out_kind_r;
  logic [7:0]         out_rd_r;
  logic signed [15:0] out_smp_r;

  // chip-side state
  logic [7:0] latched_r, latched_nxt;
  logic [1:0] sel_r, sel_nxt;

  logic advance, fire;
  logic do_latch, do_apply, do_tick;

  psg_tone_wr_t      tone_wr [3];
  psg_noise_wr_t     noise_wr;
  logic signed [4:0] tone_level [3];
  logic              tone_flip [3];
  logic signed [4:0] noise_level;
  logic signed [15:0] sample;

  assign advance  = !out_v_r || out_ready;
  assign fire     = in_v_r && advance;
  assign in_ready = !in_v_r || advance;

  always_comb begin
    do_latch = 1'b0;
    do_apply = 1'b0;
    do_tick  = 1'b0;
    unique case (psg_cmd_t'(in_cmd_r))
      CMD_LATCH:  do_latch = fire;
      CMD_READ:   do_apply = fire;
      CMD_SAMPLE: do_tick  = fire;
      CMD_NOP:    ;
      default:    ;
    endcase
  end

  // byte decode: bit7 set selects a channel, bit7 clear writes high period bits
  always_comb begin
    latched_nxt = do_latch ? in_byte_r : latched_r;
    sel_nxt     = (do_apply && latched_r[7]) ? latched_r[6:5] : sel_r;
    for (int i = 0; i < 3; i++) begin
      tone_wr[i].en   = do_apply && (latched_r[7] ? (latched_r[6:5] == 2'(i))
                                                  : (sel_r == 2'(i)));
      tone_wr[i].amp  = latched_r[7] && latched_r[4];
      tone_wr[i].lo   = latched_r[7] && !latched_r[4];
      tone_wr[i].hi   = !latched_r[7];
      tone_wr[i].data = latched_r[5:0];
    end
    noise_wr.en   = do_apply && latched_r[7] && (latched_r[6:5] == NOISE_SEL);
    noise_wr.amp  = latched_r[4];
    noise_wr.data = latched_r[3:0];
  end

  for (genvar g = 0; g < 3; g++) begin : g_tone
    psg_tone u_tone (
      .clk   (clk),
      .rst_n (rst_n),
      .wr    (tone_wr[g]),
      .tick  (do_tick),
      .level (tone_level[g]),
      .flip  (tone_flip[g])
    );
  end

  // noise can follow tone 2's flips
  psg_noise u_noise (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (noise_wr),
    .tick       (do_tick),
    .tone2_flip (tone_flip[2]),
    .level      (noise_level)
  );

  psg_mix_filter u_filter (
    .clk    (clk),
    .rst_n  (rst_n),
    .tick   (do_tick),
    .level0 (tone_level[0]),
    .level1 (tone_level[1]),
    .level2 (tone_level[2]),
    .level3 (noise_level),
    .sample (sample)
  );

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_valid && in_ready) begin
      in_v_nxt = 1'b1;
    end else if (fire) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (fire) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      latched_r <= '0;
      sel_r     <= '0;
    end else begin
      in_v_r    <= in_v_nxt;
      out_v_r   <= out_v_nxt;
      latched_r <= latched_nxt;
      sel_r     <= sel_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_cmd_r  <= in_cmd;
      in_byte_r <= in_data_byte;
    end
    if (fire) begin
      out_kind_r <= in_cmd_r;
      out_rd_r   <= do_apply ? READ_VALUE : 8'd0;
      out_smp_r  <= do_tick ? sample : 16'sd0;
    end
  end

  assign out_valid       = out_v_r;
  assign out_result_kind = out_kind_r;
  assign out_read_data   = out_rd_r;
  assign out_sample      = out_smp_r;

  // backpressure only when both registers are full and the output stalls
  `PSG_ASSERT(a_ready_stall, clk, rst_n, !in_ready |-> (in_v_r && out_v_r && !out_ready))
  // read results always carry the status value
  `PSG_ASSERT(a_read_value, clk, rst_n,
              (out_valid && out_result_kind == CMD_READ) |-> (out_read_data == READ_VALUE))
  // only sample results carry audio
  `PSG_ASSERT(a_sample_zero, clk, rst_n,
              (out_valid && out_result_kind != CMD_SAMPLE) |-> (out_sample == 16'sd0))
  // a new result is loaded only when the input stage held an item
  `PSG_ASSERT(a_out_source, clk, rst_n,
              (out_valid && !$past(out_valid)) |-> $past(in_v_r))

endmodule

@@ src/psg_tone.sv @@
// ----------------------------------------------------------------------------
// PSG tone channel
// Period, down counter and square wave level of one tone voice.
// ----------------------------------------------------------------------------
module psg_tone (
  input  logic                 clk,
  input  logic                 rst_n,
  input  psg_pkg::psg_tone_wr_t wr,
  input  logic                 tick,
  output logic signed [4:0]    level,
  output logic                 flip
);
  import psg_pkg::*;

  logic [10:0]       period_r, period_nxt;
  logic [11:0]       counter_r, counter_nxt;
  logic [3:0]        amp_r, amp_nxt;
  logic signed [4:0] level_r, level_nxt;

  always_comb begin
    logic signed [4:0] amp_s;
    logic [10:0]       p;
    amp_s       = $signed({1'b0, amp_r});
    p           = period_r;
    period_nxt  = period_r;
    counter_nxt = counter_r;
    amp_nxt     = amp_r;
    level_nxt   = level_r;
    flip        = 1'b0;
    if (wr.en) begin
      if (wr.amp) begin
        amp_nxt = 4'hF - wr.data[3:0];
      end else if (wr.lo) begin
        p = {1'b0, period_r[9:4], wr.data[3:0]};
      end else if (wr.hi) begin
        p = {1'b0, wr.data, period_r[3:0]};
      end
      // any write fixes up a zero period
      period_nxt = (p == 11'd0) ? PERIOD_ZERO : p;
    end
    if (tick) begin
      if (counter_r < TONE_TICKS) begin
        counter_nxt = {1'b0, period_r};
        flip        = 1'b1;
        level_nxt   = (level_r > 5'sd0) ? -amp_s : amp_s;
      end else begin
        counter_nxt = counter_r - TONE_TICKS;
      end
    end
  end

  assign level = level_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= '0;
      counter_r <= '0;
      amp_r     <= '0;
      level_r   <= '0;
    end else begin
      period_r  <= period_nxt;
      counter_r <= counter_nxt;
      amp_r     <= amp_nxt;
      level_r   <= level_nxt;
    end
  end

endmodule

@@ src/psg_noise.sv @@
// ----------------------------------------------------------------------------
// PSG noise channel
// Noise divider and 16-bit LFSR, clocked by its divider or by tone 2 flips.
// ----------------------------------------------------------------------------
module psg_noise (
  input  logic                  clk,
  input  logic                  rst_n,
  input  psg_pkg::psg_noise_wr_t wr,
  input  logic                  tick,
  input  logic                  tone2_flip,
  output logic signed [4:0]     level
);
  import psg_pkg::*;

  logic [4:0]        counter_r, counter_nxt;
  logic [2:0]        ctrl_r, ctrl_nxt;
  logic [3:0]        amp_r, amp_nxt;
  logic [15:0]       lfsr_r, lfsr_nxt;
  logic signed [4:0] level_r, level_nxt;

  always_comb begin
    logic        do_shift;
    logic [15:0] s;
    logic        top;
    logic signed [4:0] amp_s;
    amp_s       = $signed({1'b0, amp_r});
    do_shift    = 1'b0;
    counter_nxt = counter_r;
    ctrl_nxt    = ctrl_r;
    amp_nxt     = amp_r;
    lfsr_nxt    = lfsr_r;
    level_nxt   = level_r;
    if (wr.en) begin
      if (wr.amp) begin
        amp_nxt = 4'hF - wr.data;
      end else begin
        ctrl_nxt = wr.data[2:0];
      end
    end
    if (tick) begin
      if (ctrl_r[1:0] == NOISE_TONE2) begin
        do_shift = tone2_flip;
      end else if (counter_r < NOISE_TICKS) begin
        do_shift    = 1'b1;
        counter_nxt = 5'd2 << ctrl_r[1:0];
      end else begin
        counter_nxt = counter_r - NOISE_TICKS;
      end
    end
    // a stuck-at-zero register is reseeded before it shifts
    s   = (lfsr_r == 16'd0) ? LFSR_SEED : lfsr_r;
    top = s[0] ^ (ctrl_r[2] & s[3]);
    if (do_shift) begin
      lfsr_nxt  = {top, s[15:1]};
      level_nxt = s[1] ? amp_s : -amp_s;
    end
  end

  assign level = level_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r <= '0;
      ctrl_r    <= '0;
      amp_r     <= '0;
      lfsr_r    <= LFSR_SEED;
      level_r   <= '0;
    end else begin
      counter_r <= counter_nxt;
      ctrl_r    <= ctrl_nxt;
      amp_r     <= amp_nxt;
      lfsr_r    <= lfsr_nxt;
      level_r   <= level_nxt;
    end
  end

endmodule

@@ src/psg_mix_filter.sv @@
// ----------------------------------------------------------------------------
// PSG mixer and lowpass
// Sums the four voice levels and runs the one-pole filter acc += (x-acc)>>>3.
// ----------------------------------------------------------------------------
module psg_mix_filter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tick,
  input  logic signed [4:0]  level0,
  input  logic signed [4:0]  level1,
  input  logic signed [4:0]  level2,
  input  logic signed [4:0]  level3,
  output logic signed [15:0] sample
);
  import psg_pkg::*;

  logic signed [31:0] acc_r, acc_nxt;
  logic signed [6:0]  sum;
  logic signed [31:0] target;
  logic signed [32:0] diff;
  logic signed [32:0] step;

  assign sum    = 7'(level0) + 7'(level1) + 7'(level2) + 7'(level3);
  // each level unit weighs 2^25
  assign target = $signed({sum, 25'd0});
  assign diff   = 33'(target) - 33'(acc_r);
  assign step   = diff >>> 3;
  assign acc_nxt = acc_r + step[31:0];
  assign sample  = acc_nxt[31:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (tick) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

@@ dv/psg_result_checker.sv @@
// ----------------------------------------------------------------------------
// PSG result checker
// Watches both channels of the sound generator, predicts each result and
// compares it field by field against what comes out.
// ----------------------------------------------------------------------------
module psg_result_checker
  import psg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [7:0]         in_data_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_result_kind,
  input  logic [7:0]         out_read_data,
  input  logic signed [15:0] out_sample,
  output int                 errors,
  output int                 outstanding
);

  typedef struct packed {
    psg_cmd_t           kind;
    logic [7:0]         rd;
    logic signed [15:0] smp;
  } psg_result_t;

  psg_result_t pending_outputs[$];

  // voice state
  logic [10:0] period [3];
  logic [11:0] tcount [3];
  logic [3:0]  tamp   [3];
  int          tlevel [3];
  logic [4:0]  ncount;
  logic [2:0]  nctl;
  logic [3:0]  namp;
  logic [15:0] lfsr;
  int          nlevel;
  logic [31:0] facc;
  logic [7:0]  latch_q;
  logic [1:0]  chan_sel;

  function automatic void apply_write(logic [7:0] b);
    int ch;
    if (b[7]) begin
      chan_sel = b[6:5];
      if (chan_sel == NOISE_SEL) begin
        if (b[4]) namp = 4'd15 - b[3:0];
        else nctl = b[2:0];
      end else begin
        ch = chan_sel;
        if (b[4]) tamp[ch] = 4'd15 - b[3:0];
        else period[ch] = {1'b0, period[ch][9:4], b[3:0]};
        if (period[ch] == '0) period[ch] = PERIOD_ZERO;
      end
    end else if (chan_sel != NOISE_SEL) begin
      ch = chan_sel;
      period[ch] = {1'b0, b[5:0], period[ch][3:0]};
      if (period[ch] == '0) period[ch] = PERIOD_ZERO;
    end
  endfunction

  // returns 1 when the square wave flipped
  function automatic bit advance_tone(int ch);
    int c;
    c = int'(tcount[ch]) - int'(TICKS_PER_SAMPLE);
    if (c < 0) begin
      tcount[ch] = {1'b0, period[ch]};
      tlevel[ch] = (tlevel[ch] > 0) ? -int'(tamp[ch]) : int'(tamp[ch]);
      return 1'b1;
    end
    tcount[ch] = c[11:0];
    return 1'b0;
  endfunction

  function automatic void lfsr_advance();
    logic fb;
    if (lfsr == '0) lfsr = LFSR_SEED;
    fb = lfsr[0] ^ (nctl[2] & lfsr[3]);
    lfsr = {fb, lfsr[15:1]};
    nlevel = lfsr[0] ? int'(namp) : -int'(namp);
  endfunction

  function automatic void advance_noise(bit tone2_flip);
    int c;
    if (nctl[1:0] == NOISE_TONE2) begin
      if (tone2_flip) lfsr_advance();
    end else begin
      c = int'(ncount) - int'(TICKS_PER_SAMPLE);
      if (c < 0) begin
        lfsr_advance();
        ncount = 5'(2 << nctl[1:0]);
      end else begin
        ncount = c[4:0];
      end
    end
  endfunction

  // advance all voices, mix, lowpass; sample is the top half of the acc
  function automatic logic [15:0] mix_sample();
    bit     flip2;
    longint sum;
    longint acc;
    longint diff;
    void'(advance_tone(0));
    void'(advance_tone(1));
    flip2 = advance_tone(2);
    advance_noise(flip2);
    sum  = longint'(tlevel[0] + tlevel[1] + tlevel[2] + nlevel) * (longint'(1) << 25);
    acc  = longint'($signed(facc));
    diff = sum - acc;
    acc  = acc + (diff >>> 3);
    facc = acc[31:0];
    return facc[31:16];
  endfunction

  function automatic psg_result_t predict_result(logic [1:0] cmd, logic [7:0] b);
    psg_result_t r;
    r.kind = psg_cmd_t'(cmd);
    r.rd   = '0;
    r.smp  = '0;
    case (psg_cmd_t'(cmd))
      CMD_LATCH: latch_q = b;
      CMD_READ: begin
        apply_write(latch_q);
        r.rd = READ_VALUE;
      end
      CMD_SAMPLE: r.smp = mix_sample();
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    psg_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        period[i] = '0;
        tcount[i] = '0;
        tamp[i]   = '0;
        tlevel[i] = 0;
      end
      ncount   = '0;
      nctl     = '0;
      namp     = '0;
      lfsr     = LFSR_SEED;
      nlevel   = 0;
      facc     = '0;
      latch_q  = '0;
      chan_sel = '0;
      pending_outputs.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_outputs.size() == 0) begin
          errors++;
          $display("%0t: unexpected result kind %0d read %0d sample %0d", $time,
                   out_result_kind, out_read_data, out_sample);
        end else begin
          want = pending_outputs.pop_front();
          if (want.kind != out_result_kind) begin
            errors++;
            $display("%0t: result_kind expected %0d got %0d", $time, want.kind,
                     out_result_kind);
          end
          if (want.rd != out_read_data) begin
            errors++;
            $display("%0t: read_data expected %0d got %0d", $time, want.rd, out_read_data);
          end
          if (want.smp != out_sample) begin
            errors++;
            $display("%0t: sample expected %0d got %0d", $time, want.smp, out_sample);
          end
        end
      end
      if (in_valid && in_ready)
        pending_outputs.push_back(predict_result(in_cmd, in_data_byte));
    end
    outstanding <= pending_outputs.size();
  end

endmodule

@@ dv/tb_psg_tone_noise_generator.sv @@
// ----------------------------------------------------------------------------
// PSG tone and noise generator testbench
// Drives command items through the generator under four flow-control mixes,
// while a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_psg_tone_noise_generator;
  import psg_pkg::*;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic [1:0]         in_cmd       = CMD_NOP;
  logic [7:0]         in_data_byte = '0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic [1:0]         out_result_kind;
  logic [7:0]         out_read_data;
  logic signed [15:0] out_sample;

  int errors;
  int outstanding;

  // flow-control knobs, percent of cycles
  int idle_pct  = 0;
  int stall_pct = 0;

  // what went in, for the closing summary
  int n_items, n_samples, n_applies, n_latches, n_nops;

  psg_tone_noise_generator DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_read_data   (out_read_data),
    .out_sample      (out_sample)
  );

  psg_result_checker result_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_read_data   (out_read_data),
    .out_sample      (out_sample),
    .errors          (errors),
    .outstanding     (outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // receiver: stalls at random, at the rate of the current phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // one item: optional idle gap first, then hold valid until accepted
  task automatic send_item(psg_cmd_t cmd, logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    n_items++;
    case (cmd)
      CMD_LATCH:  n_latches++;
      CMD_READ:   n_applies++;
      CMD_SAMPLE: n_samples++;
      default:    n_nops++;
    endcase
  endtask

  // a register write is a latch followed by a port read; the read's byte is ignored
  task automatic write_reg(logic [7:0] b);
    send_item(CMD_LATCH, b);
    send_item(CMD_READ, 8'($urandom));
  endtask

  // sender goes quiet until every expected result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // register byte with a useful shape: attenuation, low period / noise control,
  // small high period (so tones flip within a few samples), or anything at all
  function automatic logic [7:0] shaped_write();
    logic [1:0] ch;
    ch = 2'($urandom_range(3));
    case ($urandom_range(3))
      0:       return {1'b1, ch, 1'b1, 4'($urandom_range(15))};
      1:       return {1'b1, ch, 1'b0, 4'($urandom)};
      2:       return {2'b00, 6'($urandom_range(3))};
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly samples and well-formed register writes, the rest loose commands
  task automatic random_burst(int n);
    int sent;
    int r;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 40) begin
        send_item(CMD_SAMPLE, 8'($urandom));
        sent++;
      end else if (r < 80) begin
        write_reg(shaped_write());
        sent += 2;
      end else begin
        send_item(psg_cmd_t'($urandom_range(3)), 8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part, no idling ---
    // samples straight out of reset: tone periods never written reload 0
    send_item(CMD_SAMPLE, 8'h00);
    send_item(CMD_NOP, 8'hFF);
    // noise at full volume, clocked by tone 2 which flips every sample
    write_reg(8'hF0);
    write_reg(8'hE3);
    send_item(CMD_SAMPLE, 8'h55);
    send_item(CMD_SAMPLE, 8'hAA);
    // high-bits byte while noise is selected: must be ignored
    write_reg(8'h2A);
    // tone 0: full volume, period 1
    write_reg(8'h90);
    write_reg(8'h81);
    write_reg(8'h00);
    // tone 1 low bits 0 with period 0 turns into 0x400
    write_reg(8'hA0);
    // noise on its own divider, white feedback
    write_reg(8'hE4);
    send_item(CMD_SAMPLE, 8'h0F);
    send_item(CMD_SAMPLE, 8'hF0);
    send_item(CMD_SAMPLE, 8'hFF);
    // all-ones byte: noise attenuation to silent
    write_reg(8'hFF);
    drain_results();

    // --- random part, four flow-control phases ---
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      random_burst(225);
      // sender holds off here until everything has come back
      drain_results();
    end

    stall_pct = 0;
    repeat (8) @(posedge clk);

    $display("covered %0d items: %0d samples, %0d register applies, %0d latches, %0d others",
             n_items, n_samples, n_applies, n_latches, n_nops);
    $display("flow control: free running, sender idle, receiver stalls, and both mixed");
    if (errors == 0 && outstanding == 0) begin
      $display("tb_psg_tone_noise_generator: clean");
    end else begin
      $display("tb_psg_tone_noise_generator: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("tb_psg_tone_noise_generator: errors");
    $finish;
  end

endmodule
